[hw/rtl/dakaf_pkg.sv]
package dakaf_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int COV_FRAC_BITS   = 24;

	localparam int DATA_W   = 32;
	localparam int GAIN_W   = 17;
	localparam int GAIN_FRAC = 16;
	localparam int MUL_A_W  = DATA_W + 1;
	localparam int PROD_W   = MUL_A_W + DATA_W;
	localparam int SUM_W    = PROD_W + 2;
	localparam int PP_W     = DATA_W + 1;
	localparam int DEN_W    = DATA_W + 2;
	localparam int NUM_W    = PP_W + GAIN_FRAC + 1;
	localparam int CNT_W    = $clog2(GAIN_W);
	localparam int PC_W     = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

	localparam logic [DATA_W-1:0] Q_RESET          = 32'd671089;
	localparam logic [DATA_W-1:0] R_RESET          = 32'd1678;
	localparam logic [DATA_W-1:0] PERIOD_RESET     = 32'd6554;
	localparam logic [DATA_W-1:0] ROLL_BIAS_RESET  = 32'd58982;
	localparam logic [DATA_W-1:0] PITCH_BIAS_RESET = 32'd0;
	localparam logic [DATA_W-1:0] COV_RESET        = DATA_W'(1) << COV_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_RATE_BIAS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATE_BIAS = 3'd4;

	typedef struct packed {
		logic signed [DATA_W-1:0] roll_meas;
		logic signed [DATA_W-1:0] pitch_meas;
		logic signed [DATA_W-1:0] roll_rate;
		logic signed [DATA_W-1:0] pitch_rate;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] roll_estimate;
		logic signed [DATA_W-1:0] pitch_estimate;
		logic [GAIN_W-1:0]        roll_gain;
		logic [GAIN_W-1:0]        pitch_gain;
	} result_t;

	typedef enum logic [3:0] {
		OP_IDLE,
		OP_RATE_MUL,
		OP_PRED,
		OP_DIV,
		OP_GAIN,
		OP_ERR_MUL,
		OP_EST,
		OP_COV_MUL,
		OP_COV,
		OP_DONE
	} op_t;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_SAMPLE,
		HOLD_LOOP,
		HOLD_RESULT
	} hold_t;

	typedef struct packed {
		op_t              op;
		logic             ax;
		hold_t            hold;
		logic [PC_W-1:0]  nxt;
	} ucode_t;

	// The control store. A word repeats while its hold condition is true, then
	// the sequencer goes to its next address.
	function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			5'd0:  w = '{OP_IDLE,     1'b0, HOLD_SAMPLE, 5'd1};
			5'd1:  w = '{OP_RATE_MUL, 1'b0, HOLD_NONE,   5'd2};
			5'd2:  w = '{OP_PRED,     1'b0, HOLD_NONE,   5'd3};
			5'd3:  w = '{OP_DIV,      1'b0, HOLD_LOOP,   5'd4};
			5'd4:  w = '{OP_GAIN,     1'b0, HOLD_NONE,   5'd5};
			5'd5:  w = '{OP_ERR_MUL,  1'b0, HOLD_NONE,   5'd6};
			5'd6:  w = '{OP_EST,      1'b0, HOLD_NONE,   5'd7};
			5'd7:  w = '{OP_COV_MUL,  1'b0, HOLD_NONE,   5'd8};
			5'd8:  w = '{OP_COV,      1'b0, HOLD_NONE,   5'd9};
			5'd9:  w = '{OP_RATE_MUL, 1'b1, HOLD_NONE,   5'd10};
			5'd10: w = '{OP_PRED,     1'b1, HOLD_NONE,   5'd11};
			5'd11: w = '{OP_DIV,      1'b1, HOLD_LOOP,   5'd12};
			5'd12: w = '{OP_GAIN,     1'b1, HOLD_NONE,   5'd13};
			5'd13: w = '{OP_ERR_MUL,  1'b1, HOLD_NONE,   5'd14};
			5'd14: w = '{OP_EST,      1'b1, HOLD_NONE,   5'd15};
			5'd15: w = '{OP_COV_MUL,  1'b1, HOLD_NONE,   5'd16};
			5'd16: w = '{OP_COV,      1'b1, HOLD_NONE,   5'd17};
			5'd17: w = '{OP_DONE,     1'b0, HOLD_RESULT, 5'd0};
			default: w = '{OP_IDLE,   1'b0, HOLD_NONE,   5'd0};
		endcase
		return w;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic all_ones;
		logic all_zeros;
		all_ones  = &v[SUM_W-1:DATA_W-1];
		all_zeros = ~(|v[SUM_W-1:DATA_W-1]);
		if (all_ones || all_zeros) begin
			return v[DATA_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

[hw/rtl/dual_axis_kalman_attitude_fusion.sv]
// A result becomes valid once both axes of its sample are processed; the sequencer waits at
// its done word while an earlier result is held by result_stall, and no new sample is taken
// until it is back at idle. Each axis runs through one shared multiplier and a 17-step
// restoring divider for the gain, sequenced by a microcode store. Reset clears the angles to
// zero, the covariances to one and the registers to their defaults; the block takes samples
// as soon as reset is released.
module dual_axis_kalman_attitude_fusion (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  dakaf_pkg::sample_t                   sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output dakaf_pkg::result_t                   result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dakaf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dakaf_pkg::DATA_W-1:0]         cfg_data
);

	localparam int DW = dakaf_pkg::DATA_W;
	localparam int GW = dakaf_pkg::GAIN_W;
	localparam int PW = dakaf_pkg::PROD_W;
	localparam int SW = dakaf_pkg::SUM_W;
	localparam int AW = dakaf_pkg::MUL_A_W;

	logic [DW-1:0]                 q_q;
	logic [DW-1:0]                 r_q;
	logic [DW-1:0]                 period_q;
	logic signed [DW-1:0]          bias_q [2];
	logic signed [DW-1:0]          angle_q [2];
	logic [DW-1:0]                 cov_q [2];

	logic [dakaf_pkg::PC_W-1:0]    pc_q;
	logic [dakaf_pkg::PC_W-1:0]    pc_next;
	logic [dakaf_pkg::CNT_W-1:0]   cnt_q;
	dakaf_pkg::ucode_t             ctl;
	logic                          hold;

	dakaf_pkg::sample_t            smp_q;
	dakaf_pkg::result_t            res_q;
	dakaf_pkg::result_t            result_q;
	logic                          result_valid_q;

	logic [PW-1:0]                 prod_q;
	logic                          neg_q;
	logic [dakaf_pkg::PP_W-1:0]    pp_q;
	logic [dakaf_pkg::DEN_W-1:0]   den_q;
	logic [dakaf_pkg::DEN_W-1:0]   rem_q;
	logic [GW-1:0]                 num_q;
	logic [GW-1:0]                 quo_q;
	logic [GW-1:0]                 gain_q;
	logic signed [DW-1:0]          pred_q;

	logic signed [DW-1:0]          meas_a;
	logic signed [DW-1:0]          rate_a;
	logic signed [AW-1:0]          rate_sum;
	logic [AW-1:0]                 rate_mag;
	logic signed [AW-1:0]          err;
	logic [AW-1:0]                 err_mag;
	logic [AW-1:0]                 mul_a;
	logic [DW-1:0]                 mul_b;
	logic [PW-1:0]                 mul_p;
	logic [PW-1:0]                 rnd_ang;
	logic [PW-1:0]                 rnd_gain;
	logic signed [SW-1:0]          delta;
	logic signed [SW-1:0]          corr;
	logic signed [DW-1:0]          pred_new;
	logic signed [DW-1:0]          est_new;
	logic [DW-1:0]                 cov_new;
	logic [dakaf_pkg::PP_W-1:0]    pp_new;
	logic [dakaf_pkg::NUM_W-1:0]   num_full;
	logic [dakaf_pkg::DEN_W:0]     div_t;
	logic                          div_ge;
	logic [GW-1:0]                 quo_clamped;
	logic [GW-1:0]                 gain_new;
	logic                          sample_xfer;
	logic                          result_xfer;

	assign ctl = dakaf_pkg::ucode(pc_q);

	always_comb begin
		case (ctl.hold)
			dakaf_pkg::HOLD_SAMPLE: hold = !sample_valid;
			dakaf_pkg::HOLD_LOOP:   hold = (cnt_q != '0);
			dakaf_pkg::HOLD_RESULT: hold = result_valid_q && result_stall;
			default:                hold = 1'b0;
		endcase
		pc_next = hold ? pc_q : ctl.nxt;
	end

	always_comb begin
		sample_stall = (ctl.op != dakaf_pkg::OP_IDLE);
		cfg_ready    = 1'b1;
		result_valid = result_valid_q;
		result       = result_q;
	end

	assign sample_xfer = sample_valid && !sample_stall;
	assign result_xfer = result_valid_q && !result_stall;

	always_comb begin
		meas_a   = ctl.ax ? smp_q.pitch_meas : smp_q.roll_meas;
		rate_a   = ctl.ax ? smp_q.pitch_rate : smp_q.roll_rate;
		rate_sum = AW'(rate_a) + AW'(bias_q[ctl.ax]);
		rate_mag = rate_sum[AW-1] ? AW'(-rate_sum) : AW'(rate_sum);
		err      = AW'(meas_a) - AW'(pred_q);
		err_mag  = err[AW-1] ? AW'(-err) : AW'(err);
		pp_new   = dakaf_pkg::PP_W'(cov_q[ctl.ax]) + dakaf_pkg::PP_W'(q_q);

		case (ctl.op)
			dakaf_pkg::OP_RATE_MUL: begin
				mul_a = rate_mag;
				mul_b = period_q;
			end
			dakaf_pkg::OP_ERR_MUL: begin
				mul_a = err_mag;
				mul_b = DW'(gain_q);
			end
			default: begin
				mul_a = AW'(pp_q);
				mul_b = DW'(dakaf_pkg::GAIN_ONE - gain_q);
			end
		endcase
		mul_p = PW'(mul_a) * PW'(mul_b);

		rnd_ang  = (prod_q + (PW'(1) << (dakaf_pkg::ANGLE_FRAC_BITS - 1)))
			>> dakaf_pkg::ANGLE_FRAC_BITS;
		rnd_gain = (prod_q + (PW'(1) << (dakaf_pkg::GAIN_FRAC - 1))) >> dakaf_pkg::GAIN_FRAC;

		delta    = neg_q ? -SW'(rnd_ang) : SW'(rnd_ang);
		pred_new = dakaf_pkg::sat32(SW'(angle_q[ctl.ax]) + delta);
		corr     = neg_q ? -SW'(rnd_gain) : SW'(rnd_gain);
		est_new  = dakaf_pkg::sat32(SW'(pred_q) + corr);
		cov_new  = (|rnd_gain[PW-1:DW]) ? '1 : rnd_gain[DW-1:0];

		num_full = {pp_q, {dakaf_pkg::GAIN_FRAC{1'b0}}}
			+ dakaf_pkg::NUM_W'(den_q >> 1);
		div_t    = {rem_q, num_q[GW-1]};
		div_ge   = (div_t >= {1'b0, den_q});

		quo_clamped = (quo_q > dakaf_pkg::GAIN_ONE) ? dakaf_pkg::GAIN_ONE : quo_q;
		gain_new    = (den_q == '0) ? '0 : quo_clamped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			q_q            <= dakaf_pkg::Q_RESET;
			r_q            <= dakaf_pkg::R_RESET;
			period_q       <= dakaf_pkg::PERIOD_RESET;
			bias_q[0]      <= dakaf_pkg::ROLL_BIAS_RESET;
			bias_q[1]      <= dakaf_pkg::PITCH_BIAS_RESET;
			angle_q[0]     <= '0;
			angle_q[1]     <= '0;
			cov_q[0]       <= dakaf_pkg::COV_RESET;
			cov_q[1]       <= dakaf_pkg::COV_RESET;
		end else begin
			pc_q <= pc_next;

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					dakaf_pkg::CFG_PROCESS_NOISE:   q_q       <= cfg_data;
					dakaf_pkg::CFG_MEASURE_NOISE:   r_q       <= cfg_data;
					dakaf_pkg::CFG_SAMPLE_PERIOD:   period_q  <= cfg_data;
					dakaf_pkg::CFG_ROLL_RATE_BIAS:  bias_q[0] <= cfg_data;
					dakaf_pkg::CFG_PITCH_RATE_BIAS: bias_q[1] <= cfg_data;
					default: ;
				endcase
			end

			if ((ctl.op == dakaf_pkg::OP_DONE) && !hold) begin
				result_valid_q <= 1'b1;
			end else if (result_xfer) begin
				result_valid_q <= 1'b0;
			end

			case (ctl.op)
				dakaf_pkg::OP_PRED: begin
					cnt_q <= dakaf_pkg::CNT_W'(GW - 1);
				end
				dakaf_pkg::OP_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				dakaf_pkg::OP_EST: begin
					angle_q[ctl.ax] <= est_new;
				end
				dakaf_pkg::OP_COV: begin
					cov_q[ctl.ax] <= cov_new;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_xfer) begin
			smp_q <= sample;
		end
		case (ctl.op)
			dakaf_pkg::OP_RATE_MUL: begin
				prod_q <= mul_p;
				neg_q  <= rate_sum[AW-1];
				pp_q   <= pp_new;
				den_q  <= dakaf_pkg::DEN_W'(pp_new) + dakaf_pkg::DEN_W'(r_q);
			end
			dakaf_pkg::OP_PRED: begin
				pred_q <= pred_new;
				rem_q  <= dakaf_pkg::DEN_W'(num_full[dakaf_pkg::NUM_W-1:GW]);
				num_q  <= num_full[GW-1:0];
				quo_q  <= '0;
			end
			dakaf_pkg::OP_DIV: begin
				rem_q <= div_ge ? dakaf_pkg::DEN_W'(div_t - {1'b0, den_q})
					: div_t[dakaf_pkg::DEN_W-1:0];
				quo_q <= {quo_q[GW-2:0], div_ge};
				num_q <= {num_q[GW-2:0], 1'b0};
			end
			dakaf_pkg::OP_GAIN: begin
				gain_q <= gain_new;
			end
			dakaf_pkg::OP_ERR_MUL: begin
				prod_q <= mul_p;
				neg_q  <= err[AW-1];
			end
			dakaf_pkg::OP_EST: begin
				if (ctl.ax) begin
					res_q.pitch_estimate <= est_new;
					res_q.pitch_gain     <= gain_q;
				end else begin
					res_q.roll_estimate <= est_new;
					res_q.roll_gain     <= gain_q;
				end
			end
			dakaf_pkg::OP_COV_MUL: begin
				prod_q <= mul_p;
			end
			dakaf_pkg::OP_DONE: begin
				if (!hold) begin
					result_q <= res_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[tb/sv/tb_dual_axis_kalman_attitude_fusion.sv]
module tb_dual_axis_kalman_attitude_fusion;
	timeunit 1ns;
	timeprecision 1ps;

	import dakaf_pkg::*;

	localparam longint ANGLE_MAX = 64'sd2147483647;
	localparam longint ANGLE_MIN = -64'sd2147483648;
	localparam int unsigned ANGLE_SPAN = 90 * 65536;
	localparam int unsigned RATE_SPAN = 500 * 65536;
	localparam int unsigned BIAS_SPAN = 5 * 65536;
	localparam int BATCHES = 8;
	localparam int BATCH_ITEMS = 205;
	localparam int SQUEEZE_CYCLES = 1500;
	localparam int DRAIN_CYCLES = 60;

	class fusion_tracker;
		logic [DATA_W-1:0] q_var;
		logic [DATA_W-1:0] r_var;
		logic [DATA_W-1:0] period;
		logic signed [DATA_W-1:0] bias [2];
		logic signed [DATA_W-1:0] angle [2];
		logic [DATA_W-1:0] cov [2];
		result_t fused_due [$];
		int errors;

		function new();
			q_var = Q_RESET;
			r_var = R_RESET;
			period = PERIOD_RESET;
			bias[0] = ROLL_BIAS_RESET;
			bias[1] = PITCH_BIAS_RESET;
			angle[0] = '0;
			angle[1] = '0;
			cov[0] = COV_RESET;
			cov[1] = COV_RESET;
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
			case (idx)
				CFG_PROCESS_NOISE: q_var = data;
				CFG_MEASURE_NOISE: r_var = data;
				CFG_SAMPLE_PERIOD: period = data;
				CFG_ROLL_RATE_BIAS: bias[0] = data;
				CFG_PITCH_RATE_BIAS: bias[1] = data;
				default: ;
			endcase
		endfunction

		// Multiplies by an unsigned factor and shifts right, rounding halves away from zero.
		function longint round_scale(input longint v, input logic [63:0] m, input int sh);
			logic [127:0] mag;
			logic [127:0] p;
			bit neg;
			neg = v < 0;
			mag = neg ? 128'(-v) : 128'(v);
			p = (mag * 128'(m) + (128'(1) << (sh - 1))) >> sh;
			return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
		endfunction

		function logic signed [DATA_W-1:0] clamp_angle(input longint v);
			if (v > ANGLE_MAX) begin
				return DATA_W'(ANGLE_MAX);
			end else if (v < ANGLE_MIN) begin
				return DATA_W'(ANGLE_MIN);
			end
			return DATA_W'(v);
		endfunction

		function void step_axis(input int ax, input logic signed [DATA_W-1:0] meas,
				input logic signed [DATA_W-1:0] rate, output logic signed [DATA_W-1:0] est,
				output logic [GAIN_W-1:0] gain);
			longint rate_c;
			longint pred;
			longint err;
			logic [63:0] pp;
			logic [63:0] den;
			logic [63:0] g;
			logic [63:0] np;
			rate_c = longint'(rate) + longint'(bias[ax]);
			pred = clamp_angle(longint'(angle[ax])
				+ round_scale(rate_c, 64'(period), ANGLE_FRAC_BITS));
			pp = 64'(cov[ax]) + 64'(q_var);
			den = pp + 64'(r_var);
			g = '0;
			np = '0;
			if (den != 0) begin
				g = ((pp << GAIN_FRAC) + (den >> 1)) / den;
				if (g > 64'(GAIN_ONE)) begin
					g = 64'(GAIN_ONE);
				end
				np = ((64'(GAIN_ONE) - g) * pp + (64'(1) << (GAIN_FRAC - 1))) >> GAIN_FRAC;
				if (np > 64'hFFFF_FFFF) begin
					np = 64'hFFFF_FFFF;
				end
			end
			err = longint'(meas) - pred;
			est = clamp_angle(pred + round_scale(err, g, GAIN_FRAC));
			angle[ax] = est;
			cov[ax] = np[DATA_W-1:0];
			gain = g[GAIN_W-1:0];
		endfunction

		function void take_sample(input sample_t s);
			result_t want;
			logic signed [DATA_W-1:0] est;
			logic [GAIN_W-1:0] gain;
			step_axis(0, s.roll_meas, s.roll_rate, est, gain);
			want.roll_estimate = est;
			want.roll_gain = gain;
			step_axis(1, s.pitch_meas, s.pitch_rate, est, gain);
			want.pitch_estimate = est;
			want.pitch_gain = gain;
			fused_due.push_back(want);
		endfunction

		function void match_field(input string name, input logic [DATA_W-1:0] want,
				input logic [DATA_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_fused(input result_t got);
			result_t want;
			if (fused_due.size() == 0) begin
				$error("result transfer with no sample outstanding: %0h", got);
				errors++;
				return;
			end
			want = fused_due.pop_front();
			match_field("roll_estimate", want.roll_estimate, got.roll_estimate);
			match_field("pitch_estimate", want.pitch_estimate, got.pitch_estimate);
			match_field("roll_gain", DATA_W'(want.roll_gain), DATA_W'(got.roll_gain));
			match_field("pitch_gain", DATA_W'(want.pitch_gain), DATA_W'(got.pitch_gain));
		endfunction

		function int pending();
			return fused_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	bit squeeze_req;

	fusion_tracker fusion = new();

	dual_axis_kalman_attitude_fusion dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sample_t make_sample(input logic [DATA_W-1:0] rm, input logic [DATA_W-1:0] pm,
			input logic [DATA_W-1:0] rr, input logic [DATA_W-1:0] pr);
		return sample_t'({rm, pm, rr, pr});
	endfunction

	function automatic logic [DATA_W-1:0] random_word(input int unsigned span);
		int unsigned r;
		r = $urandom_range(9, 0);
		if (r < 5) begin
			return DATA_W'($urandom_range(2 * span, 0)) - DATA_W'(span);
		end else if (r < 8) begin
			return $urandom;
		end else if (r < 9) begin
			return DATA_W'($urandom_range(2000, 0)) - DATA_W'(1000);
		end
		case ($urandom_range(3, 0))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_setting(input logic [DATA_W-1:0] typical,
			input logic [DATA_W-1:0] dflt);
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			2: return $urandom;
			3: return dflt;
			default: return $urandom_range(typical, 0);
		endcase
	endfunction

	function automatic sample_t random_sample();
		return make_sample(random_word(ANGLE_SPAN), random_word(ANGLE_SPAN),
			random_word(RATE_SPAN), random_word(RATE_SPAN));
	endfunction

	// Entered and left at a falling edge.
	task automatic send_sample(input sample_t s);
		int r;
		int gap;
		r = $urandom_range(99, 0);
		if (r < 60) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(6, 1);
		end else if (r < 98) begin
			gap = $urandom_range(40, 7);
		end else begin
			gap = $urandom_range(200, 41);
		end
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample = s;
		sample_valid = 1'b1;
		do @(posedge clk); while (sample_stall);
		fusion.take_sample(s);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		fusion.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] r,
			input logic [DATA_W-1:0] period, input logic [DATA_W-1:0] roll_bias,
			input logic [DATA_W-1:0] pitch_bias);
		write_reg(CFG_PROCESS_NOISE, q);
		write_reg(CFG_MEASURE_NOISE, r);
		write_reg(CFG_SAMPLE_PERIOD, period);
		write_reg(CFG_ROLL_RATE_BIAS, roll_bias);
		write_reg(CFG_PITCH_RATE_BIAS, pitch_bias);
		write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, CFG_PITCH_RATE_BIAS + 1)),
			$urandom);
		cfg_valid = 1'b0;
	endtask

	task automatic finish_batch();
		sample_valid = 1'b0;
		while (fusion.pending() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_valid && !result_stall) begin
			fusion.check_fused(result);
		end
	end

	initial begin
		int mode;
		result_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				result_stall = 1'b1;
				repeat (SQUEEZE_CYCLES) @(negedge clk);
			end else begin
				mode = $urandom_range(39, 0);
				if (mode < 16) begin
					result_stall = 1'b0;
					repeat ($urandom_range(80, 1)) @(negedge clk);
				end else if (mode < 32) begin
					repeat ($urandom_range(40, 1)) begin
						result_stall = $urandom_range(1, 0);
						@(negedge clk);
					end
				end else if (mode < 38) begin
					result_stall = 1'b1;
					repeat ($urandom_range(12, 1)) @(negedge clk);
				end else begin
					result_stall = 1'b1;
					repeat ($urandom_range(300, 40)) @(negedge clk);
				end
			end
		end
	end

	initial begin
		#100ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		squeeze_req = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_settings(Q_RESET, R_RESET, PERIOD_RESET, ROLL_BIAS_RESET, PITCH_BIAS_RESET);
		send_sample(make_sample(32'h0, 32'h0, 32'h0, 32'h0));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_sample(make_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		send_sample(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1));
		send_sample(make_sample(32'h005A_0000, 32'hFFA6_0000, 32'h0, 32'h0));
		send_sample(make_sample(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
		finish_batch();

		// With no noise the covariance collapses, so the next step has a zero denominator.
		load_settings('0, '0, '1, 32'h7FFF_FFFF, 32'h8000_0000);
		send_sample(make_sample(32'h0, 32'h0, 32'h0, 32'h0));
		send_sample(make_sample(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
		finish_batch();

		load_settings('1, '1, '0, '0, '0);
		send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h8765_4321));
		send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1));
		send_sample(make_sample(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0));
		finish_batch();

		load_settings(32'h0000_0001, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
		send_sample(make_sample(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
		send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
		send_sample(make_sample(32'h0, 32'h0, 32'h0, 32'h0));
		finish_batch();

		for (int ph = 0; ph < BATCHES; ph++) begin
			load_settings(random_setting(32'h0100_0000, Q_RESET),
				random_setting(32'h0100_0000, R_RESET),
				random_setting(32'h0001_0000, PERIOD_RESET),
				random_word(BIAS_SPAN), random_word(BIAS_SPAN));
			if (ph == 0 || ph == BATCHES / 2) begin
				squeeze_req = 1'b1;
			end
			repeat (BATCH_ITEMS) send_sample(random_sample());
			finish_batch();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fusion.errors == 0 && fusion.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/dakaf_pkg.sv
hw/rtl/dual_axis_kalman_attitude_fusion.sv
tb/sv/tb_dual_axis_kalman_attitude_fusion.sv
